// ===== src/ambient_led_frame_receiver_top_assert.svh =====
// Assertion macros shared by the frame receiver modules.
// Needs a clock and an active-low reset in scope; no other dependencies.
`ifndef AMBIENT_LED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define AMBIENT_LED_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define ALFR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define ALFR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/alfr_pkg.sv =====
// Shared constants, types and helpers for the ambient LED frame receiver.
// No dependencies.
package alfr_pkg;

    localparam int ZONE_COUNT  = 32;
    localparam int ZONE_W      = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int ZONE_IDX_W  = 5;
    localparam int LEVEL_W     = 7;
    localparam int STORE_W     = 3 * LEVEL_W;
    localparam int HDR_LEN     = 3;
    localparam int HDR_CNT_W   = $clog2(HDR_LEN + 1);

    localparam logic [7:0]        MAGIC_0   = 8'h41;  // 'A'
    localparam logic [7:0]        MAGIC_1   = 8'h64;  // 'd'
    localparam logic [7:0]        MAGIC_2   = 8'h61;  // 'a'
    localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(ZONE_COUNT - 1);

    typedef enum logic [1:0] {
        ST_MAGIC0,
        ST_MAGIC1,
        ST_MAGIC2,
        ST_PAYLOAD
    } parse_state_t;

    typedef enum logic [1:0] {
        COMP_RED,
        COMP_GREEN,
        COMP_BLUE
    } comp_t;

    typedef struct packed {
        logic                en;
        logic [ZONE_W-1:0]   addr;
        logic [STORE_W-1:0]  data;
    } wr_t;

    typedef struct packed {
        logic                en;
        logic [ZONE_W-1:0]   addr;
    } rd_t;

    function automatic logic [ZONE_IDX_W-1:0] to_zone_index(input logic [ZONE_W-1:0] z);
        logic [ZONE_W+ZONE_IDX_W-1:0] wide;
        wide = {{ZONE_IDX_W{1'b0}}, z};
        return wide[ZONE_IDX_W-1:0];
    endfunction

endpackage

// ===== src/ambient_led_frame_receiver_top.sv =====
// channel   direction  handshake            payload
// rx        in         in_valid / in_stall  rx_byte
// result    out        out_valid/out_stall  zone_index, red/green/blue_level, frame_end
//
// Input: one byte a cycle; colour bytes stall while the previous frame is read out.
// Output: one result per zone (store read, then output load), ZONE_COUNT a frame; one read in flight at most.
// Magic and header bytes of the next frame are taken during readout.
// Reset clears parser and readout control; the colour store needs no clearing pass.
// Output stalls hold the result register and pause store reads.
module ambient_led_frame_receiver_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [alfr_pkg::ZONE_IDX_W-1:0] zone_index,
    output logic [alfr_pkg::LEVEL_W-1:0]    red_level,
    output logic [alfr_pkg::LEVEL_W-1:0]    green_level,
    output logic [alfr_pkg::LEVEL_W-1:0]    blue_level,
    output logic                            frame_end
);
    import alfr_pkg::*;

    wr_t                wr;
    rd_t                rd;
    logic [STORE_W-1:0] rd_data;
    logic               frame_start;
    logic               emit_busy;

    alfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .emit_busy   (emit_busy),
        .wr          (wr),
        .frame_start (frame_start)
    );

    alfr_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    alfr_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_start (frame_start),
        .emit_busy   (emit_busy),
        .rd          (rd),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .zone_index  (zone_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .frame_end   (frame_end)
    );

endmodule

// ===== src/alfr_store.sv =====
// Colour store: one word per zone holding three 7-bit levels.
// One write port, one read port with registered data. Depends on alfr_pkg.
module alfr_store (
    input  logic                    clk,
    input  alfr_pkg::wr_t           wr,
    input  alfr_pkg::rd_t           rd,
    output logic [alfr_pkg::STORE_W-1:0] rd_data
);
    import alfr_pkg::*;

    logic [STORE_W-1:0] mem [ZONE_COUNT];
    logic [STORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/alfr_parser.sv =====
// Byte parser: magic hunt, header skip, colour collection into the store.
// Depends on alfr_pkg and the assertion macro header.
`include "ambient_led_frame_receiver_top_assert.svh"

module alfr_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          emit_busy,
    output alfr_pkg::wr_t wr,
    output logic          frame_start
);
    import alfr_pkg::*;

    parse_state_t          state_reg, state_next;
    logic [HDR_CNT_W-1:0]  hdr_reg, hdr_next;
    comp_t                 comp_reg, comp_next;
    logic [ZONE_W-1:0]     zone_reg, zone_next;
    logic [LEVEL_W-1:0]    red_reg, red_next;
    logic [LEVEL_W-1:0]    green_reg, green_next;
    logic                  colour_phase;
    logic                  accept;

    // colour bytes wait while the previous frame is still being read out
    assign colour_phase = (state_reg == ST_PAYLOAD) && (hdr_reg == HDR_CNT_W'(HDR_LEN));
    assign in_stall     = colour_phase && emit_busy;
    assign accept       = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MAGIC0;
            hdr_reg   <= '0;
            comp_reg  <= COMP_RED;
            zone_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hdr_reg   <= hdr_next;
            comp_reg  <= comp_next;
            zone_reg  <= zone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        hdr_next    = hdr_reg;
        comp_next   = comp_reg;
        zone_next   = zone_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        wr.en       = 1'b0;
        wr.addr     = zone_reg;
        wr.data     = {red_reg, green_reg, rx_byte[7:1]};
        frame_start = 1'b0;

        unique case (state_reg)
            ST_MAGIC0:
            begin
                if (accept && rx_byte == MAGIC_0)
                begin
                    state_next = ST_MAGIC1;
                end
            end
            ST_MAGIC1:
            begin
                if (accept && rx_byte == MAGIC_1)
                begin
                    state_next = ST_MAGIC2;
                end
            end
            ST_MAGIC2:
            begin
                if (accept && rx_byte == MAGIC_2)
                begin
                    state_next = ST_PAYLOAD;
                    hdr_next   = '0;
                    comp_next  = COMP_RED;
                    zone_next  = '0;
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    if (!colour_phase)
                    begin
                        hdr_next = hdr_reg + HDR_CNT_W'(1);
                    end
                    else
                    begin
                        unique case (comp_reg)
                            COMP_RED:
                            begin
                                red_next  = rx_byte[7:1];
                                comp_next = COMP_GREEN;
                            end
                            COMP_GREEN:
                            begin
                                green_next = rx_byte[7:1];
                                comp_next  = COMP_BLUE;
                            end
                            COMP_BLUE:
                            begin
                                wr.en     = 1'b1;
                                comp_next = COMP_RED;
                                if (zone_reg == LAST_ZONE)
                                begin
                                    frame_start = 1'b1;
                                    state_next  = ST_MAGIC0;
                                    hdr_next    = '0;
                                    zone_next   = '0;
                                end
                                else
                                begin
                                    zone_next = zone_reg + ZONE_W'(1);
                                end
                            end
                            default:
                            begin
                                comp_next = COMP_RED;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_MAGIC0;
            end
        endcase
    end

    `ALFR_ASSERT_NOW(a_wr_in_payload, clk, rst_n, wr.en, colour_phase && !emit_busy,
        "store write outside colour phase or during readout")
    `ALFR_ASSERT_NOW(a_start_on_last, clk, rst_n, frame_start, wr.en && zone_reg == LAST_ZONE,
        "frame start without the last zone being written")
    `ALFR_ASSERT_NEXT(a_start_rehunt, clk, rst_n, frame_start,
        state_reg == ST_MAGIC0 && zone_reg == '0, "parser did not return to magic hunt")

endmodule

// ===== src/alfr_emitter.sv =====
// Frame readout: walks the colour store zone by zone into the output register.
// Depends on alfr_pkg and the assertion macro header.
`include "ambient_led_frame_receiver_top_assert.svh"

module alfr_emitter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            frame_start,
    output logic                            emit_busy,
    output alfr_pkg::rd_t                   rd,
    input  logic [alfr_pkg::STORE_W-1:0]    rd_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [alfr_pkg::ZONE_IDX_W-1:0] zone_index,
    output logic [alfr_pkg::LEVEL_W-1:0]    red_level,
    output logic [alfr_pkg::LEVEL_W-1:0]    green_level,
    output logic [alfr_pkg::LEVEL_W-1:0]    blue_level,
    output logic                            frame_end
);
    import alfr_pkg::*;

    logic                   busy_reg;
    logic [ZONE_W-1:0]      rd_zone_reg;
    logic                   pend_reg;
    logic [ZONE_W-1:0]      pend_zone_reg;
    logic                   out_valid_reg;
    logic [ZONE_IDX_W-1:0]  zone_index_reg;
    logic [LEVEL_W-1:0]     red_reg;
    logic [LEVEL_W-1:0]     green_reg;
    logic [LEVEL_W-1:0]     blue_reg;
    logic                   frame_end_reg;
    logic                   issue;

    // one read in flight at most; the output slot is free by the time data lands
    assign issue     = busy_reg && !pend_reg && (!out_valid_reg || !out_stall);
    assign rd.en     = issue;
    assign rd.addr   = rd_zone_reg;
    assign emit_busy = busy_reg || pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_zone_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_start)
            begin
                busy_reg    <= 1'b1;
                rd_zone_reg <= '0;
            end
            else if (issue)
            begin
                if (rd_zone_reg == LAST_ZONE)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rd_zone_reg <= rd_zone_reg + ZONE_W'(1);
                end
            end
            pend_reg <= issue;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_zone_reg <= rd_zone_reg;
        end
        if (pend_reg)
        begin
            zone_index_reg <= to_zone_index(pend_zone_reg);
            red_reg        <= rd_data[3*LEVEL_W-1:2*LEVEL_W];
            green_reg      <= rd_data[2*LEVEL_W-1:LEVEL_W];
            blue_reg       <= rd_data[LEVEL_W-1:0];
            frame_end_reg  <= (pend_zone_reg == LAST_ZONE);
        end
    end

    assign out_valid   = out_valid_reg;
    assign zone_index  = zone_index_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;
    assign frame_end   = frame_end_reg;

    `ALFR_ASSERT_NOW(a_slot_free, clk, rst_n, pend_reg, !out_valid_reg,
        "read data arrived while the output register was occupied")
    `ALFR_ASSERT_NOW(a_start_idle, clk, rst_n, frame_start, !busy_reg && !pend_reg,
        "new frame started during readout")
    `ALFR_ASSERT_NEXT(a_issue_lands, clk, rst_n, issue && rd_zone_reg == LAST_ZONE,
        pend_reg && !busy_reg, "readout did not finish after the last zone")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for ambient_led_frame_receiver_top: serial frame hunt and zone readout.
// Depends on alfr_pkg and the receiver RTL; predicts zone results in a small scoreboard class.
`timescale 1ns / 100ps

module tb_top;
    import alfr_pkg::*;

    localparam int FRAME_BYTES = HDR_LEN + 3 * ZONE_COUNT;

    typedef struct {
        logic [ZONE_IDX_W-1:0] zone;
        logic [LEVEL_W-1:0]    red;
        logic [LEVEL_W-1:0]    green;
        logic [LEVEL_W-1:0]    blue;
        logic                  last;
    } zone_colour_t;

    function automatic logic [7:0] magic_for(parse_state_t st);
        case (st)
            ST_MAGIC0: return MAGIC_0;
            ST_MAGIC1: return MAGIC_1;
            default:   return MAGIC_2;
        endcase
    endfunction

    class frame_scoreboard;
        parse_state_t  stage;
        int            count;
        logic [7:0]    colour_bytes [3*ZONE_COUNT];
        zone_colour_t  zones_due [$];
        int            errors;

        function new();
            stage  = ST_MAGIC0;
            count  = 0;
            errors = 0;
            foreach (colour_bytes[i])
                colour_bytes[i] = 8'h00;
        endfunction

        // one accepted rx request
        function void note_byte(logic [7:0] b);
            zone_colour_t zc;
            if (stage != ST_PAYLOAD)
            begin
                // a wrong byte holds the hunt where it is
                if (b == magic_for(stage))
                begin
                    stage = parse_state_t'(stage + 1);
                    if (stage == ST_PAYLOAD)
                        count = 0;
                end
                return;
            end
            if (count >= HDR_LEN)
                colour_bytes[count - HDR_LEN] = b;
            count++;
            if (count == FRAME_BYTES)
            begin
                stage = ST_MAGIC0;
                count = 0;
                for (int z = 0; z < ZONE_COUNT; z++)
                begin
                    zc.zone  = z[ZONE_IDX_W-1:0];
                    zc.red   = colour_bytes[3*z][7:1];
                    zc.green = colour_bytes[3*z+1][7:1];
                    zc.blue  = colour_bytes[3*z+2][7:1];
                    zc.last  = (z == ZONE_COUNT - 1);
                    zones_due.push_back(zc);
                end
            end
        endfunction

        function void check_result(zone_colour_t got);
            zone_colour_t want;
            if (zones_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result zone %0d r %0d g %0d b %0d end %0b",
                             $time, got.zone, got.red, got.green, got.blue, got.last);
                return;
            end
            want = zones_due.pop_front();
            if (got.zone !== want.zone || got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch exp z%0d r%0d g%0d b%0d e%0b, ",
                              "got z%0d r%0d g%0d b%0d e%0b"},
                             $time, want.zone, want.red, want.green, want.blue, want.last,
                             got.zone, got.red, got.green, got.blue, got.last);
            end
        endfunction

        function int pending();
            return zones_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [ZONE_IDX_W-1:0] zone_index;
    logic [LEVEL_W-1:0]    red_level;
    logic [LEVEL_W-1:0]    green_level;
    logic [LEVEL_W-1:0]    blue_level;
    logic                  frame_end;

    frame_scoreboard sb = new();

    ambient_led_frame_receiver_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .zone_index  (zone_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .frame_end   (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // colour bytes lean on the ends of the range
    function automatic logic [7:0] colour_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'hFE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_byte(rx_byte);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{zone_index, red_level, green_level, blue_level, frame_end});
    end

    // called and returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_frame();
        bit         steady;
        logic [7:0] b;
        steady = ($urandom_range(0, 3) == 0);
        if (sb.stage == ST_MAGIC0)
            repeat ($urandom_range(0, 5))
                push_byte(8'($urandom_range(0, 255)), steady ? 0 : idle_len());
        while (sb.stage != ST_PAYLOAD)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == magic_for(sb.stage))
                    b ^= 8'h80;
            end
            else
                b = magic_for(sb.stage);
            push_byte(b, steady ? 0 : idle_len());
        end
        while (sb.stage == ST_PAYLOAD)
        begin
            b = (sb.count < HDR_LEN) ? 8'($urandom_range(0, 255)) : colour_byte();
            push_byte(b, steady ? 0 : idle_len());
        end
    endtask

    initial
    begin
        int run;
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            out_stall <= 1'b0;
            repeat (run) @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] opening [$];
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hunt with wrong bytes at every stage, then header extremes
        opening = '{8'h00, 8'hFF, MAGIC_1, MAGIC_2, MAGIC_0, MAGIC_0, 8'h00, MAGIC_1,
                    MAGIC_1, MAGIC_0, 8'hFF, MAGIC_2, 8'hFF, 8'h00, 8'h5A};
        foreach (opening[i])
            push_byte(opening[i], idle_len());

        // first pass finishes the frame already under way
        repeat (3)
            send_frame();
        repeat (50)
            push_byte(8'($urandom_range(0, 255)), idle_len());
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
